@@ hw/rtl/servo_keyframe_recorder_player_top_defines.svh @@
// ----------------------------------------------------------------------------
// Servo keyframe recorder/player assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SERVO_KEYFRAME_RECORDER_PLAYER_TOP_DEFINES_SVH
`define SERVO_KEYFRAME_RECORDER_PLAYER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SKRP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SKRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/skrp_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo keyframe recorder/player package
// Command codes, status codes, the keyframe record and the default sequence.
// ----------------------------------------------------------------------------
package skrp_pkg;

   // Command kinds carried by a request transaction.
   localparam logic [3:0] KIND_START_REC    = 4'd0;
   localparam logic [3:0] KIND_RECORD       = 4'd1;
   localparam logic [3:0] KIND_STOP_REC     = 4'd2;
   localparam logic [3:0] KIND_UNDO         = 4'd3;
   localparam logic [3:0] KIND_CLEAR        = 4'd4;
   localparam logic [3:0] KIND_LOAD_DEFAULT = 4'd5;
   localparam logic [3:0] KIND_PLAY         = 4'd6;
   localparam logic [3:0] KIND_TICK         = 4'd7;
   localparam logic [3:0] KIND_READ         = 4'd8;

   // Status codes carried by a response transaction.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ARG   = 2'd1;
   localparam logic [1:0] ST_STATE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // Accepted angle window and tick period.
   localparam logic [7:0]  ANGLE_MIN = 8'd120;
   localparam logic [7:0]  ANGLE_MAX = 8'd150;
   localparam logic [31:0] TICK_MS   = 32'd10;

   // Default sequence: three frames spaced five seconds apart.
   localparam int unsigned  DEFAULT_COUNT = 3;
   localparam logic [31:0]  DEFAULT_STEP1 = 32'd5000;
   localparam logic [31:0]  DEFAULT_STEP2 = 32'd10000;

   // One stored keyframe.
   typedef struct packed {
      logic [7:0]  left;
      logic [7:0]  right;
      logic [31:0] stamp;
   } frame_type;

   // Frame k of the default sequence based at the given time.
   function automatic frame_type default_frame(input logic [1:0] k, input logic [31:0] base);
      frame_type f;
      unique case (k)
         2'd1: begin
            f.left  = ANGLE_MAX;
            f.right = ANGLE_MAX;
            f.stamp = base + DEFAULT_STEP1;
         end
         2'd2: begin
            f.left  = ANGLE_MIN;
            f.right = ANGLE_MIN;
            f.stamp = base + DEFAULT_STEP2;
         end
         default: begin
            f.left  = ANGLE_MIN;
            f.right = ANGLE_MIN;
            f.stamp = base;
         end
      endcase
      return f;
   endfunction

endpackage

@@ hw/rtl/servo_keyframe_recorder_player_top.sv @@
// ----------------------------------------------------------------------------
// Servo keyframe recorder/player
// Records timestamped left/right servo keyframes and replays them on 10 ms
// ticks, one result per command or a left/right servo pair per fired frame.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   req     | in        | req_valid/req_stall | kind, angles, time_ms, index
//   rsp     | out       | rsp_valid/rsp_stall | status, mode, servo, read-back
//
// A transaction is registered with its two frame-store reads on acceptance and
// resolved from the request stage into the response register once that frees.
// One transaction per cycle is taken when each gives a single response and rsp
// is not stalled; a fired frame fills the response register with two results
// (left servo, then right servo), one after the other in that single register.
// Reset clears the control state only; the frame store is not cleared.
// A stalled response holds the stage behind it, which then stalls req.
//
`include "servo_keyframe_recorder_player_top_defines.svh"

module servo_keyframe_recorder_player_top #(
   parameter int unsigned MAX_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_kind,
   input  logic [7:0]  req_left_angle,
   input  logic [7:0]  req_right_angle,
   input  logic [31:0] req_time_ms,
   input  logic [5:0]  req_index,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_recording,
   output logic        rsp_playing,
   output logic [6:0]  rsp_frame_total,
   output logic        rsp_is_full,
   output logic        rsp_servo_valid,
   output logic        rsp_servo_id,
   output logic [7:0]  rsp_servo_angle,
   output logic [7:0]  rsp_read_left,
   output logic [7:0]  rsp_read_right,
   output logic [31:0] rsp_read_time,
   output logic        rsp_last
);

   localparam int unsigned AW = $clog2(MAX_FRAMES);
   localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

   // Frame store, read at two addresses per accepted transaction.
   skrp_pkg::frame_type frame_mem [MAX_FRAMES];

   // Request stage registers.
   logic                s1_valid_ff, s1_valid_in;
   logic [3:0]          s1_kind_ff;
   logic [7:0]          s1_left_ff;
   logic [7:0]          s1_right_ff;
   logic [31:0]         s1_time_ff;
   logic [5:0]          s1_index_ff;
   logic [AW-1:0]       s1_addr_a_ff;
   logic [AW-1:0]       s1_addr_b_ff;
   skrp_pkg::frame_type mem_a_ff;
   skrp_pkg::frame_type mem_b_ff;
   logic                byp_a_ff;
   logic                byp_b_ff;
   skrp_pkg::frame_type byp_data_ff;

   // Architectural state.
   logic [CW-1:0] count_ff, count_in;
   logic          rec_ff, rec_in;
   logic          play_ff, play_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [31:0]   rem_ms_ff, rem_ms_in;
   logic          dflt_ff, dflt_in;
   logic [31:0]   dbase_ff, dbase_in;

   // Response registers.
   logic          rsp_valid_ff;
   logic          pend_ff;
   logic [7:0]    pend_angle_ff;
   logic [1:0]    rsp_status_ff;
   logic          rsp_recording_ff;
   logic          rsp_playing_ff;
   logic [6:0]    rsp_frame_total_ff;
   logic          rsp_is_full_ff;
   logic          rsp_servo_valid_ff;
   logic          rsp_servo_id_ff;
   logic [7:0]    rsp_servo_angle_ff;
   logic [7:0]    rsp_read_left_ff;
   logic [7:0]    rsp_read_right_ff;
   logic [31:0]   rsp_read_time_ff;
   logic          rsp_last_ff;

   // Handshake and datapath wires.
   logic                out_free, exec, accept;
   logic [AW-1:0]       rd_addr_a, rd_addr_b;
   logic [AW+5:0]       idx_addr_wide;
   logic [CW-1:0]       pos_in_next;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   skrp_pkg::frame_type wr_data;
   skrp_pkg::frame_type frame_a, frame_b;
   logic [CW+5:0]       idx_wide, cnt_wide;
   logic [CW-1:0]       fire_pos;
   logic [CW-1:0]       fire_next;
   logic                fire;
   logic                read_ok;
   logic [1:0]          status;
   logic [CW+6:0]       total_wide;

   // Handshake: the request stage moves on when the response register frees.
   assign out_free  = !rsp_valid_ff || (!rsp_stall && !pend_ff);
   assign exec      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign s1_valid_in = accept ? 1'b1 : (exec ? 1'b0 : s1_valid_ff);

   // Read addresses use the state as it stands after the resolving transaction.
   assign idx_addr_wide = {{AW{1'b0}}, req_index};
   assign pos_in_next   = pos_in + CW'(1);

   always_comb begin
      unique case (req_kind)
         skrp_pkg::KIND_PLAY: begin
            rd_addr_a = '0;
            rd_addr_b = AW'(1);
         end
         skrp_pkg::KIND_TICK: begin
            rd_addr_a = pos_in[AW-1:0];
            rd_addr_b = pos_in_next[AW-1:0];
         end
         skrp_pkg::KIND_READ: begin
            rd_addr_a = idx_addr_wide[AW-1:0];
            rd_addr_b = '0;
         end
         default: begin
            rd_addr_a = '0;
            rd_addr_b = '0;
         end
      endcase
   end

   // Frame store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         mem_a_ff <= frame_mem[rd_addr_a];
         mem_b_ff <= frame_mem[rd_addr_b];
      end
   end

   // Request stage payload, with forwarding of a write in the same cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_kind;
         s1_left_ff   <= req_left_angle;
         s1_right_ff  <= req_right_angle;
         s1_time_ff   <= req_time_ms;
         s1_index_ff  <= req_index;
         s1_addr_a_ff <= rd_addr_a;
         s1_addr_b_ff <= rd_addr_b;
         byp_a_ff     <= wr_en && (wr_addr == rd_addr_a);
         byp_b_ff     <= wr_en && (wr_addr == rd_addr_b);
         byp_data_ff  <= wr_data;
      end
   end

   // The default sequence lives as an overlay over the first three entries.
   always_comb begin
      if (dflt_ff && (s1_addr_a_ff < AW'(skrp_pkg::DEFAULT_COUNT))) begin
         frame_a = skrp_pkg::default_frame(s1_addr_a_ff[1:0], dbase_ff);
      end else if (byp_a_ff) begin
         frame_a = byp_data_ff;
      end else begin
         frame_a = mem_a_ff;
      end
      if (dflt_ff && (s1_addr_b_ff < AW'(skrp_pkg::DEFAULT_COUNT))) begin
         frame_b = skrp_pkg::default_frame(s1_addr_b_ff[1:0], dbase_ff);
      end else if (byp_b_ff) begin
         frame_b = byp_data_ff;
      end else begin
         frame_b = mem_b_ff;
      end
   end

   assign idx_wide = {{CW{1'b0}}, s1_index_ff};
   assign cnt_wide = {6'b0, count_ff};
   assign wr_data  = '{left: s1_left_ff, right: s1_right_ff, stamp: s1_time_ff};
   assign wr_addr  = count_ff[AW-1:0];

   // Command resolution.
   always_comb begin
      count_in  = count_ff;
      rec_in    = rec_ff;
      play_in   = play_ff;
      pos_in    = pos_ff;
      rem_ms_in = rem_ms_ff;
      dflt_in   = dflt_ff;
      dbase_in  = dbase_ff;
      wr_en     = 1'b0;
      fire      = 1'b0;
      read_ok   = 1'b0;
      status    = skrp_pkg::ST_OK;
      fire_pos  = pos_ff;

      if (exec) begin
         unique case (s1_kind_ff)
            skrp_pkg::KIND_START_REC: begin
               if (rec_ff) begin
                  status = skrp_pkg::ST_STATE;
               end else begin
                  count_in = '0;
                  rec_in   = 1'b1;
                  dflt_in  = 1'b0;
               end
            end
            skrp_pkg::KIND_RECORD: begin
               priority if (s1_left_ff < skrp_pkg::ANGLE_MIN ||
                            s1_left_ff > skrp_pkg::ANGLE_MAX ||
                            s1_right_ff < skrp_pkg::ANGLE_MIN ||
                            s1_right_ff > skrp_pkg::ANGLE_MAX) begin
                  status = skrp_pkg::ST_ARG;
               end else if (!rec_ff) begin
                  status = skrp_pkg::ST_STATE;
               end else if (count_ff == CW'(MAX_FRAMES)) begin
                  status = skrp_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            skrp_pkg::KIND_STOP_REC: begin
               if (!rec_ff) begin
                  status = skrp_pkg::ST_STATE;
               end else begin
                  rec_in = 1'b0;
               end
            end
            skrp_pkg::KIND_UNDO: begin
               if (count_ff == '0) begin
                  status = skrp_pkg::ST_STATE;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            skrp_pkg::KIND_CLEAR: begin
               count_in  = '0;
               rec_in    = 1'b0;
               play_in   = 1'b0;
               rem_ms_in = '0;
               dflt_in   = 1'b0;
            end
            skrp_pkg::KIND_LOAD_DEFAULT: begin
               count_in  = CW'(skrp_pkg::DEFAULT_COUNT);
               rec_in    = 1'b0;
               play_in   = 1'b0;
               rem_ms_in = '0;
               dflt_in   = 1'b1;
               dbase_in  = s1_time_ff;
            end
            skrp_pkg::KIND_PLAY: begin
               if (count_ff == '0) begin
                  status = skrp_pkg::ST_STATE;
               end else begin
                  fire     = 1'b1;
                  fire_pos = '0;
               end
            end
            skrp_pkg::KIND_TICK: begin
               if (play_ff) begin
                  priority if (rem_ms_ff > skrp_pkg::TICK_MS) begin
                     rem_ms_in = rem_ms_ff - skrp_pkg::TICK_MS;
                  end else if (pos_ff < count_ff) begin
                     fire = 1'b1;
                  end else begin
                     play_in   = 1'b0;
                     rem_ms_in = '0;
                  end
               end
            end
            skrp_pkg::KIND_READ: begin
               if (idx_wide < cnt_wide) begin
                  read_ok = 1'b1;
               end else begin
                  status = skrp_pkg::ST_ARG;
               end
            end
            default: begin
               status = skrp_pkg::ST_ARG;
            end
         endcase

         // Firing a frame schedules the following one, or ends playback.
         if (fire) begin
            pos_in = fire_next;
            if (fire_next < count_in) begin
               play_in   = 1'b1;
               rem_ms_in = frame_b.stamp - frame_a.stamp;
            end else begin
               play_in   = 1'b0;
               rem_ms_in = '0;
            end
         end
      end
   end

   assign fire_next  = fire_pos + CW'(1);
   assign total_wide = {7'b0, count_in};

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rec_ff    <= 1'b0;
         play_ff   <= 1'b0;
         pos_ff    <= '0;
         rem_ms_ff <= '0;
         dflt_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rec_ff    <= rec_in;
         play_ff   <= play_in;
         pos_ff    <= pos_in;
         rem_ms_ff <= rem_ms_in;
         dflt_ff   <= dflt_in;
      end
   end

   always_ff @(posedge clock) begin
      dbase_ff <= dbase_in;
   end

   // Stage and response control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (exec) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= fire;
         end else if (rsp_valid_ff && !rsp_stall) begin
            if (pend_ff) begin
               pend_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   // Response payload; a fired frame shows the left servo, then the right one.
   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_status_ff      <= status;
         rsp_recording_ff   <= rec_in;
         rsp_playing_ff     <= play_in;
         rsp_frame_total_ff <= total_wide[6:0];
         rsp_is_full_ff     <= (count_in == CW'(MAX_FRAMES));
         rsp_servo_valid_ff <= fire;
         rsp_servo_id_ff    <= 1'b0;
         rsp_servo_angle_ff <= fire ? frame_a.left : 8'd0;
         rsp_read_left_ff   <= read_ok ? frame_a.left : 8'd0;
         rsp_read_right_ff  <= read_ok ? frame_a.right : 8'd0;
         rsp_read_time_ff   <= read_ok ? frame_a.stamp : 32'd0;
         rsp_last_ff        <= !fire;
         pend_angle_ff      <= frame_a.right;
      end else if (rsp_valid_ff && !rsp_stall && pend_ff) begin
         rsp_servo_id_ff    <= 1'b1;
         rsp_servo_angle_ff <= pend_angle_ff;
         rsp_last_ff        <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_recording   = rsp_recording_ff;
   assign rsp_playing     = rsp_playing_ff;
   assign rsp_frame_total = rsp_frame_total_ff;
   assign rsp_is_full     = rsp_is_full_ff;
   assign rsp_servo_valid = rsp_servo_valid_ff;
   assign rsp_servo_id    = rsp_servo_id_ff;
   assign rsp_servo_angle = rsp_servo_angle_ff;
   assign rsp_read_left   = rsp_read_left_ff;
   assign rsp_read_right  = rsp_read_right_ff;
   assign rsp_read_time   = rsp_read_time_ff;
   assign rsp_last        = rsp_last_ff;

   // Checks on the store count, the response pairing and the tick countdown.
   `SKRP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_FRAMES), "count over depth")
   `SKRP_ASSERT_IMPLY(a_pend_first, clock, reset, pend_ff, rsp_valid_ff && rsp_servo_valid_ff && !rsp_servo_id_ff && !rsp_last_ff, "pending pair not on left servo")
   `SKRP_ASSERT_NEXT(a_pair_second, clock, reset, rsp_valid_ff && !rsp_stall && pend_ff, rsp_valid_ff && rsp_servo_id_ff && rsp_last_ff && !pend_ff, "right servo result missing")
   `SKRP_ASSERT_IMPLY(a_idle_no_delay, clock, reset, !play_ff, rem_ms_ff == 32'd0, "delay left while not playing")

endmodule
